// File: rtl/lwf_pkg.sv
// types, codes and constants shared by the window fill command generator
// no dependencies; compile first
`default_nettype none

package lwf_pkg;

    // screen dimension width and repeat count width
    localparam int unsigned DIM_W = 9;
    localparam int unsigned CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // request codes
    typedef enum logic [1:0] {
        CMD_FILL   = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_ROTATE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // controller opcodes
    localparam logic [15:0] OP_COLUMN   = 16'h002A;
    localparam logic [15:0] OP_PAGE     = 16'h002B;
    localparam logic [15:0] OP_MEMWRITE = 16'h002C;
    localparam logic [15:0] OP_ACCESS   = 16'h0036;

    // access-control mode bits
    localparam logic [7:0] MADCTL_MY  = 8'h80;
    localparam logic [7:0] MADCTL_MX  = 8'h40;
    localparam logic [7:0] MADCTL_MV  = 8'h20;
    localparam logic [7:0] MADCTL_BGR = 8'h08;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] x_origin;
        logic [15:0] y_origin;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] colour;
        logic [7:0]  rotation;
    } t_req;

    typedef struct packed {
        logic             is_data;
        logic [15:0]      word_value;
        logic             is_wide;
        logic [CNT_W-1:0] repeat_count;
        logic             last;
    } t_res;

    // one evaluated request, ready for the output sequencer
    typedef struct packed {
        logic             rotate;
        logic [7:0]       mode;
        logic [15:0]      x_start;
        logic [15:0]      x_end;
        logic [15:0]      y_start;
        logic [15:0]      y_end;
        logic [15:0]      colour;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_job;

    function automatic logic [7:0] mode_byte(input logic [1:0] rot);
        logic [7:0] m;
        case (rot)
            2'd0:    m = MADCTL_MX | MADCTL_BGR;
            2'd1:    m = MADCTL_MV | MADCTL_BGR;
            2'd2:    m = MADCTL_MY | MADCTL_BGR;
            default: m = MADCTL_MX | MADCTL_MY | MADCTL_MV | MADCTL_BGR;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lwf_if.sv
// valid/ready channel interfaces for requests and result words
// depends on lwf_pkg
`default_nettype none

interface lwf_req_if import lwf_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lwf_res_if import lwf_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lwf_req_eval.sv
// request register, screen size state, off-screen check and clipping
// depends on lwf_pkg
`default_nettype none

module lwf_req_eval import lwf_pkg::*; #(
    parameter int unsigned SHORT_SIDE = 240,
    parameter int unsigned LONG_SIDE  = 320
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_job_valid,
    input  wire logic i_job_ready,
    output t_job      o_job
);

    localparam logic [DIM_W-1:0] SHORT_DIM = DIM_W'(SHORT_SIDE);
    localparam logic [DIM_W-1:0] LONG_DIM  = DIM_W'(LONG_SIDE);

    logic             r_in_v;
    t_req             r_req;
    logic [DIM_W-1:0] r_scr_w;
    logic [DIM_W-1:0] r_scr_h;

    t_cmd        cmd;
    logic        off_screen;
    logic        no_result;
    logic        take;
    logic [16:0] x_sum;
    logic [16:0] y_sum;
    logic        x_clip;
    logic        y_clip;
    logic [15:0] w_c;
    logic [15:0] h_c;

    always_comb begin
        cmd        = t_cmd'(r_req.cmd);
        off_screen = (r_req.x_origin >= 16'(r_scr_w)) || (r_req.y_origin >= 16'(r_scr_h));
        no_result  = (cmd == CMD_NONE) || ((cmd != CMD_ROTATE) && off_screen);

        // clip only nonzero sizes that run past the edge
        x_sum  = 17'(r_req.x_origin) + 17'(r_req.rect_width) - 17'd1;
        y_sum  = 17'(r_req.y_origin) + 17'(r_req.rect_height) - 17'd1;
        x_clip = (r_req.rect_width != 16'd0) && (x_sum >= 17'(r_scr_w));
        y_clip = (r_req.rect_height != 16'd0) && (y_sum >= 17'(r_scr_h));
        w_c    = x_clip ? (16'(r_scr_w) - r_req.x_origin) : r_req.rect_width;
        h_c    = y_clip ? (16'(r_scr_h) - r_req.y_origin) : r_req.rect_height;

        o_job.rotate  = (cmd == CMD_ROTATE);
        o_job.mode    = mode_byte(r_req.rotation[1:0]);
        o_job.x_start = r_req.x_origin;
        o_job.y_start = r_req.y_origin;
        o_job.colour  = r_req.colour;
        if (cmd == CMD_PIXEL) begin
            o_job.x_end = r_req.x_origin + 16'd1;
            o_job.y_end = r_req.y_origin + 16'd1;
            o_job.w     = DIM_W'(1);
            o_job.h     = DIM_W'(1);
        end else begin
            // zero size wraps the window end below the origin
            o_job.x_end = r_req.x_origin + w_c - 16'd1;
            o_job.y_end = r_req.y_origin + h_c - 16'd1;
            o_job.w     = w_c[DIM_W-1:0];
            o_job.h     = h_c[DIM_W-1:0];
        end

        o_job_valid = r_in_v && !no_result;
        take        = r_in_v && (no_result || i_job_ready);
        o_ready     = !r_in_v || take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_scr_w <= SHORT_DIM;
            r_scr_h <= LONG_DIM;
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end
            if (take && (cmd == CMD_ROTATE)) begin
                r_scr_w <= r_req.rotation[0] ? LONG_DIM : SHORT_DIM;
                r_scr_h <= r_req.rotation[0] ? SHORT_DIM : LONG_DIM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lwf_emit.sv
// job register, pixel count multiplier and output sequencer that sends one word per cycle unless the result side stalls
// depends on lwf_pkg
`default_nettype none

module lwf_emit import lwf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    localparam logic [2:0] SEQ_COL_CMD  = 3'd0;
    localparam logic [2:0] SEQ_X_START  = 3'd1;
    localparam logic [2:0] SEQ_X_END    = 3'd2;
    localparam logic [2:0] SEQ_PAGE_CMD = 3'd3;
    localparam logic [2:0] SEQ_Y_START  = 3'd4;
    localparam logic [2:0] SEQ_Y_END    = 3'd5;
    localparam logic [2:0] SEQ_MEMWR    = 3'd6;
    localparam logic [2:0] SEQ_RUN      = 3'd7;

    logic             r_job_v;
    t_job             r_job;
    logic [2:0]       r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_v;
    t_res             r_out;

    logic [2*DIM_W-1:0] prod;
    logic               fire;
    t_res               word;

    always_comb begin
        word = '{is_data: 1'b1, word_value: 16'd0, is_wide: 1'b1,
                 repeat_count: CNT_W'(1), last: 1'b0};
        if (r_job.rotate) begin
            word.is_wide = 1'b0;
            if (r_idx[0]) begin
                word.word_value = 16'(r_job.mode);
                word.last       = 1'b1;
            end else begin
                word.is_data    = 1'b0;
                word.word_value = OP_ACCESS;
            end
        end else begin
            unique case (r_idx)
                SEQ_COL_CMD: begin
                    word.is_data    = 1'b0;
                    word.is_wide    = 1'b0;
                    word.word_value = OP_COLUMN;
                end
                SEQ_X_START: word.word_value = r_job.x_start;
                SEQ_X_END:   word.word_value = r_job.x_end;
                SEQ_PAGE_CMD: begin
                    word.is_data    = 1'b0;
                    word.is_wide    = 1'b0;
                    word.word_value = OP_PAGE;
                end
                SEQ_Y_START: word.word_value = r_job.y_start;
                SEQ_Y_END:   word.word_value = r_job.y_end;
                SEQ_MEMWR: begin
                    word.is_data    = 1'b0;
                    word.is_wide    = 1'b0;
                    word.word_value = OP_MEMWRITE;
                end
                SEQ_RUN: begin
                    word.word_value   = r_job.colour;
                    word.repeat_count = r_cnt;
                    word.last         = 1'b1;
                end
                default: word.last = 1'b1;
            endcase
        end

        fire        = r_job_v && (!r_out_v || i_ready);
        o_job_ready = !r_job_v || (fire && word.last);
        prod        = (2*DIM_W)'(r_job.w) * (2*DIM_W)'(r_job.h);
        o_valid     = r_out_v;
        o_res       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_out_v <= 1'b0;
            r_idx   <= SEQ_COL_CMD;
        end else begin
            if (o_job_ready) begin
                r_job_v <= i_job_valid;
                r_idx   <= SEQ_COL_CMD;
            end else if (fire) begin
                r_idx <= r_idx + 3'd1;
            end
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_job <= i_job;
        end
        if (fire) begin
            r_out <= word;
        end
        // count settles in the cycle after the job loads, long before the run word
        r_cnt <= (prod > (2*DIM_W)'(CNT_MAX)) ? CNT_MAX : prod[CNT_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/lcd_window_fill_command_generator.sv
// Clipped rectangle fill command generator. Each accepted request becomes a
// stream of command bytes and data words for a TFT display controller: a fill
// or pixel request yields column window (opcode, start, end), page window
// (opcode, start, end), memory write and one colour word whose repeat count is
// the pixel count; a rotation request yields the access-control opcode and its
// mode byte and sets the stored screen size (landscape for odd rotations). A
// fill or pixel whose origin lies off screen, and the unused code, give no
// words. A request is held in the input register while it is evaluated
// (off-screen check and clipping), then is handed to the output sequencer,
// which sends one word per cycle, unless the result side stalls, through a
// result register: 8 words per fill or pixel, 2 per rotation. The sequencer
// is the bottleneck; the next request is already evaluated while the previous
// one drains, so words of back-to-back drawing requests follow without gaps.
// depends on lwf_pkg, lwf_if, lwf_req_eval, lwf_emit
`default_nettype none

module lcd_window_fill_command_generator import lwf_pkg::*; #(
    parameter int unsigned SHORT_SIDE = 240,
    parameter int unsigned LONG_SIDE  = 320
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lwf_req_if.sink    i_req,
    lwf_res_if.source  o_res
);

    // evaluated request handed to the sequencer
    logic job_valid;
    logic job_ready;
    t_job job;

    // input register, screen size and clipping
    lwf_req_eval #(
        .SHORT_SIDE (SHORT_SIDE),
        .LONG_SIDE  (LONG_SIDE)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_req       (i_req.data),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // word sequencer and result register
    lwf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_res       (o_res.data)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for lcd_window_fill_command_generator: directed and random requests,
// every result word checked against an in-bench prediction of the word stream
// depends on lwf_pkg, lwf_if and the generator rtl

module testbench;
    import lwf_pkg::*;

    localparam int unsigned SHORT_SIDE = 240;
    localparam int unsigned LONG_SIDE  = 320;

    logic i_clk;
    logic i_rst_n;

    lwf_req_if req_ch ();
    lwf_res_if res_ch ();

    lcd_window_fill_command_generator #(
        .SHORT_SIDE (SHORT_SIDE),
        .LONG_SIDE  (LONG_SIDE)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // predicted screen size, tracks the rotation requests
    logic [DIM_W-1:0] screen_w;
    logic [DIM_W-1:0] screen_h;

    // word stream still owed by the block, oldest first
    t_res pending_words[$];

    int mismatches;
    int drawing_reqs;  // accepted requests that produce words
    bit no_idle;       // both sides run flat out while set

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void push_word(input logic is_data, input logic [15:0] value,
                                      input logic is_wide, input logic [CNT_W-1:0] count,
                                      input logic is_last);
        t_res w;
        w.is_data      = is_data;
        w.word_value   = value;
        w.is_wide      = is_wide;
        w.repeat_count = count;
        w.last         = is_last;
        pending_words.push_back(w);
    endfunction

    // column window, page window, then memory write
    function automatic void push_window(input logic [15:0] x1, input logic [15:0] y1,
                                        input logic [15:0] x2, input logic [15:0] y2);
        push_word(1'b0, OP_COLUMN, 1'b0, 1, 1'b0);
        push_word(1'b1, x1, 1'b1, 1, 1'b0);
        push_word(1'b1, x2, 1'b1, 1, 1'b0);
        push_word(1'b0, OP_PAGE, 1'b0, 1, 1'b0);
        push_word(1'b1, y1, 1'b1, 1, 1'b0);
        push_word(1'b1, y2, 1'b1, 1, 1'b0);
        push_word(1'b0, OP_MEMWRITE, 1'b0, 1, 1'b0);
    endfunction

    // queues the words one request gives, returns how many
    function automatic int predict_words(input t_req r);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] pixels;
        logic [CNT_W-1:0] run;
        logic [7:0] mode;
        t_cmd op;
        x  = {16'h0, r.x_origin};
        y  = {16'h0, r.y_origin};
        w  = {16'h0, r.rect_width};
        h  = {16'h0, r.rect_height};
        op = t_cmd'(r.cmd);
        case (op)
            CMD_ROTATE: begin
                case (r.rotation[1:0])
                    2'd0:    mode = MADCTL_MX | MADCTL_BGR;
                    2'd1:    mode = MADCTL_MV | MADCTL_BGR;
                    2'd2:    mode = MADCTL_MY | MADCTL_BGR;
                    default: mode = MADCTL_MX | MADCTL_MY | MADCTL_MV | MADCTL_BGR;
                endcase
                push_word(1'b0, OP_ACCESS, 1'b0, 1, 1'b0);
                push_word(1'b1, {8'h00, mode}, 1'b0, 1, 1'b1);
                // odd rotations are landscape
                if (r.rotation[0]) begin
                    screen_w = DIM_W'(LONG_SIDE);
                    screen_h = DIM_W'(SHORT_SIDE);
                end else begin
                    screen_w = DIM_W'(SHORT_SIDE);
                    screen_h = DIM_W'(LONG_SIDE);
                end
                return 2;
            end
            CMD_NONE: return 0;
            default: begin
                if (x >= screen_w || y >= screen_h)
                    return 0;
                if (op == CMD_PIXEL) begin
                    push_window(x[15:0], y[15:0], x[15:0] + 16'd1, y[15:0] + 16'd1);
                    push_word(1'b1, r.colour, 1'b1, 1, 1'b1);
                end else begin
                    // clip to the screen, zero sizes pass through untouched
                    if (w != 0 && x + w - 1 >= screen_w)
                        w = screen_w - x;
                    if (h != 0 && y + h - 1 >= screen_h)
                        h = screen_h - y;
                    pixels = w * h;
                    run = (pixels > CNT_MAX) ? CNT_MAX : pixels[CNT_W-1:0];
                    push_window(x[15:0], y[15:0], x[15:0] + w[15:0] - 16'd1,
                                y[15:0] + h[15:0] - 16'd1);
                    push_word(1'b1, r.colour, 1'b1, run, 1'b1);
                end
                return 8;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_res want;
        t_res got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual data=%0b value=0x%0h",
                         $time, got.is_data, got.word_value);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                report_field("is_data", want.is_data, got.is_data);
                report_field("word_value", want.word_value, got.word_value);
                report_field("is_wide", want.is_wide, got.is_wide);
                report_field("repeat_count", want.repeat_count, got.repeat_count);
                report_field("last", want.last, got.last);
            end
        end
    end

    // result side backpressure
    always @(negedge i_clk)
        res_ch.ready <= no_idle || ($urandom_range(99) >= 28);

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // entered and left at a falling edge; valid stays high into the next call
    task automatic send_req(input t_req r);
        while (!no_idle && $urandom_range(99) < 28) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        if (predict_words(r) > 0)
            drawing_reqs++;
        @(negedge i_clk);
    endtask

    function automatic t_req make_req(input t_cmd op, input logic [15:0] x,
                                      input logic [15:0] y, input logic [15:0] w,
                                      input logic [15:0] h, input logic [15:0] col,
                                      input logic [7:0] rot);
        t_req r;
        r.cmd         = op;
        r.x_origin    = x;
        r.y_origin    = y;
        r.rect_width  = w;
        r.rect_height = h;
        r.colour      = col;
        r.rotation    = rot;
        return r;
    endfunction

    // mostly on screen, sometimes at or past the edge
    function automatic logic [15:0] rand_origin(input int unsigned limit);
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'(limit - 1);
            2:       return 16'(limit);
            default: return 16'($urandom_range(limit - 1));
        endcase
    endfunction

    // small sizes dominate, with zero, oversize and full range mixed in
    function automatic logic [15:0] rand_size(input int unsigned limit);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(limit, 1));
            default: return 16'($urandom_range(16, 1));
        endcase
    endfunction

    task automatic test_fill_extremes;
        send_req(make_req(CMD_FILL, 0, 0, 240, 320, 16'hFFFF, 0));
        send_req(make_req(CMD_FILL, 239, 319, 1, 1, 16'h0000, 0));
        send_req(make_req(CMD_FILL, 100, 200, 16'hFFFF, 16'hFFFF, 16'hA5A5, 0));
        // zero sizes wrap the window end and give an empty run
        send_req(make_req(CMD_FILL, 10, 10, 0, 5, 16'h5A5A, 0));
        send_req(make_req(CMD_FILL, 10, 10, 5, 0, 16'h1234, 0));
        send_req(make_req(CMD_FILL, 0, 0, 0, 0, 16'hFFFF, 8'hFF));
        // horizontal and vertical lines
        send_req(make_req(CMD_FILL, 0, 160, 240, 1, 16'hF800, 0));
        send_req(make_req(CMD_FILL, 120, 0, 1, 320, 16'h07E0, 0));
        // origin off screen
        send_req(make_req(CMD_FILL, 240, 0, 1, 1, 16'h001F, 0));
        send_req(make_req(CMD_FILL, 0, 320, 1, 1, 16'h001F, 0));
        send_req(make_req(CMD_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_pixels;
        send_req(make_req(CMD_PIXEL, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        send_req(make_req(CMD_PIXEL, 239, 319, 0, 0, 16'h0000, 0));
        send_req(make_req(CMD_PIXEL, 240, 0, 1, 1, 16'h1111, 0));
        send_req(make_req(CMD_PIXEL, 0, 320, 1, 1, 16'h2222, 0));
    endtask

    task automatic test_rotations;
        // upper bits of the rotation field are don't care
        send_req(make_req(CMD_ROTATE, 0, 0, 0, 0, 0, 8'hFD));
        send_req(make_req(CMD_FILL, 300, 200, 16'hFFFF, 16'hFFFF, 16'hBEEF, 0));
        send_req(make_req(CMD_PIXEL, 319, 239, 0, 0, 16'hCAFE, 0));
        send_req(make_req(CMD_FILL, 100, 240, 1, 1, 16'hCAFE, 0));
        send_req(make_req(CMD_ROTATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h02));
        send_req(make_req(CMD_FILL, 300, 10, 1, 1, 16'h0F0F, 0));
        send_req(make_req(CMD_ROTATE, 0, 0, 0, 0, 0, 8'h03));
        send_req(make_req(CMD_ROTATE, 0, 0, 0, 0, 0, 8'h00));
    endtask

    task automatic test_unused_code;
        send_req(make_req(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_req(make_req(CMD_NONE, 0, 0, 1, 1, 0, 0));
    endtask

    // random request mix until the given number of word-producing requests
    task automatic test_random_mix(input int count);
        int target;
        int pick;
        t_cmd op;
        int unsigned lim_x;
        int unsigned lim_y;
        target = drawing_reqs + count;
        while (drawing_reqs < target) begin
            pick = $urandom_range(99);
            if (pick < 10)
                op = CMD_ROTATE;
            else if (pick < 14)
                op = CMD_NONE;
            else if (pick < 40)
                op = CMD_PIXEL;
            else
                op = CMD_FILL;
            lim_x = 32'(screen_w);
            lim_y = 32'(screen_h);
            send_req(make_req(op, rand_origin(lim_x), rand_origin(lim_y),
                              rand_size(lim_x), rand_size(lim_y),
                              16'($urandom), 8'($urandom)));
        end
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        test_random_mix(count);
        no_idle = 1'b0;
    endtask

    initial begin
        mismatches   = 0;
        drawing_reqs = 0;
        no_idle      = 1'b0;
        screen_w     = DIM_W'(SHORT_SIDE);
        screen_h     = DIM_W'(LONG_SIDE);
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_fill_extremes();
        test_pixels();
        test_rotations();
        test_unused_code();
        test_random_mix(90);
        test_back_to_back(60);
        test_random_mix(120);
        req_ch.valid <= 1'b0;

        // drain, then give the pipeline time to show any stray word
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: lcd_window_fill_command_generator.f
rtl/lwf_pkg.sv
rtl/lwf_if.sv
rtl/lwf_req_eval.sv
rtl/lwf_emit.sv
rtl/lcd_window_fill_command_generator.sv
tb/testbench.sv
